// ===== hdl/fbav_pkg.sv =====
package fbav_pkg;

	// parse phases, one-hot
	typedef enum logic [7:0] {
		PH_IDLE = 8'b0000_0001,
		PH_HDR  = 8'b0000_0010,
		PH_AVER = 8'b0000_0100,
		PH_ALEN = 8'b0000_1000,
		PH_AFIX = 8'b0001_0000,
		PH_TL   = 8'b0010_0000,
		PH_DATA = 8'b0100_0000,
		PH_PAD  = 8'b1000_0000
	} phase_t;

	localparam int ERR_W = 11;
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] REG_CAE = 3'd0;

	typedef logic [ERR_W-1:0] errs_t;

	localparam errs_t E_HVER   = 11'h001;
	localparam errs_t E_OFFS   = 11'h002;
	localparam errs_t E_HSUM   = 11'h004;
	localparam errs_t E_AVER   = 11'h008;
	localparam errs_t E_LANG   = 11'h010;
	localparam errs_t E_PREDEF = 11'h020;
	localparam errs_t E_FILEID = 11'h040;
	localparam errs_t E_END    = 11'h080;
	localparam errs_t E_PAD    = 11'h100;
	localparam errs_t E_CKMISS = 11'h200;
	localparam errs_t E_CKBAD  = 11'h400;

	localparam logic [7:0] END_MARK = 8'hC1;
	localparam logic [7:0] TL_LEN_MASK = 8'h3F;
	localparam logic [7:0] FMT_VERSION = 8'h01;
	localparam logic [7:0] BOARD_OFFSET = 8'h01;

	localparam logic [7:0] OLD_HDR [0:7] = '{
		8'h01, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'hF7
	};

endpackage

// ===== hdl/fru_board_area_validator.sv =====
// FRU board info area validator.
// Image bytes arrive on the s_ stream, one per request, in address order;
// s_tuser high marks header byte 0 of a new image and restarts the parse
// (an unfinished image then gives no result). Bytes outside a parse are dropped.
// Each byte is checked in the cycle it is taken: the 8-byte common header,
// then the board area walk (version, length, language, type/length fields,
// end marker, padding, zero-sum checksum).
// One result goes out on the m_ stream when the parse ends: at the area end,
// at the first error when continue_after_error is 0, or after the header when
// the area offset is wrong. m_tvalid rises in the cycle after the last byte is
// taken; throughput is one byte per cycle unless a stalled receiver holds up the
// input, set by the single state register update per byte.
// The result sits in an output register; a new byte is taken while it waits
// as long as it is being taken in the same cycle or the slot is empty, so a
// stalled receiver only holds up the input while a result is pending.
// Reset clears the parse to idle and continue_after_error to 0. The user must only
// write it over the APB port, address 0, while idle; the block does not enforce it.
module fru_board_area_validator #(
	parameter int AREA_LENGTH_UNIT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [fbav_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// image byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] image_byte
	input  logic        s_tuser,   // [0] image_start
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [10:0] error_flags, [11] image_valid, [12] old_layout
);

	fbav_pkg::phase_t phase_q, n_phase;
	logic [3:0]  pos_q, n_pos;
	logic [11:0] left_q, n_left;
	logic [5:0]  fbl_q, n_fbl;
	logic [2:0]  fcnt_q, n_fcnt;
	logic [7:0]  hsum_q, n_hsum;
	logic [7:0]  asum_q, n_asum;
	logic        oldm_q, n_oldm;
	fbav_pkg::errs_t errs_q, n_errs;
	logic [7:0]  ver_q, n_ver;
	logic [7:0]  offs_q, n_offs;
	logic        cae_q;
	logic        res;
	logic        halt;
	logic        accept;
	logic [7:0]  b;
	logic [11:0] total;
	logic [11:0] left0;
	logic        out_valid_q;
	logic [15:0] out_data_q;

	assign b = s_tdata;
	assign accept = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign pready = 1'b1;
	assign prdata = (paddr == fbav_pkg::REG_CAE) ? {31'd0, cae_q} : 32'd0;
	assign total = oldm_q ? {4'd0, b} : 12'(b * AREA_LENGTH_UNIT);
	assign left0 = left_q;

	always_comb begin
		n_phase = phase_q;
		n_pos = pos_q;
		n_left = left_q;
		n_fbl = fbl_q;
		n_fcnt = fcnt_q;
		n_hsum = hsum_q;
		n_asum = asum_q;
		n_oldm = oldm_q;
		n_errs = errs_q;
		n_ver = ver_q;
		n_offs = offs_q;
		res = 1'b0;
		halt = 1'b0;

		if (s_tuser) begin
			n_phase = fbav_pkg::PH_HDR;
			n_pos = 4'd0;
			n_left = 12'd0;
			n_fbl = 6'd0;
			n_fcnt = 3'd0;
			n_hsum = 8'd0;
			n_asum = 8'd0;
			n_oldm = 1'b1;
			n_errs = '0;
			n_ver = 8'd0;
			n_offs = 8'd0;
		end

		case (n_phase)
			fbav_pkg::PH_IDLE: begin
			end
			fbav_pkg::PH_HDR: begin
				n_hsum = n_hsum + b;
				if (b != fbav_pkg::OLD_HDR[n_pos[2:0]])
					n_oldm = 1'b0;
				if (n_pos == 4'd0)
					n_ver = b;
				if (n_pos == 4'd3)
					n_offs = b;
				n_pos = n_pos + 4'd1;
				if (n_pos >= 4'd8) begin
					n_pos = 4'd0;
					n_phase = fbav_pkg::PH_AVER;
					if (!n_oldm) begin
						if (n_ver != fbav_pkg::FMT_VERSION) begin
							n_errs = n_errs | fbav_pkg::E_HVER;
							if (!cae_q) begin
								n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
							end
						end
						if (!halt && n_hsum != 8'd0) begin
							n_errs = n_errs | fbav_pkg::E_HSUM;
							if (!cae_q) begin
								n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
							end
						end
						if (!halt && n_offs != fbav_pkg::BOARD_OFFSET) begin
							n_errs = n_errs | fbav_pkg::E_OFFS;
							n_phase = fbav_pkg::PH_IDLE; res = 1'b1;
						end
					end
				end
			end
			fbav_pkg::PH_AVER: begin
				n_asum = b;
				n_ver = b;
				n_offs = 8'd0;
				n_pos = 4'd1;
				n_phase = fbav_pkg::PH_ALEN;
			end
			fbav_pkg::PH_ALEN: begin
				n_asum = n_asum + b;
				n_pos = 4'd2;
				if (total < 12'd6) begin
					n_errs = n_errs | fbav_pkg::E_PREDEF;
					if (!cae_q) begin
						n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
					end
					if (!halt) begin
						if (n_ver != fbav_pkg::FMT_VERSION)
							n_errs = n_errs | fbav_pkg::E_AVER;
						if (total <= 12'd2) begin
							// area too short to hold anything past the length
							n_errs = n_errs | fbav_pkg::E_END | fbav_pkg::E_CKMISS;
							if (total == 12'd2 && n_asum != 8'd0)
								n_errs = n_errs | fbav_pkg::E_CKBAD;
							n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
						end
					end
				end else if (n_ver != fbav_pkg::FMT_VERSION) begin
					n_errs = n_errs | fbav_pkg::E_AVER;
					if (!cae_q) begin
						n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
					end
				end
				if (!halt) begin
					n_left = total - 12'd2;
					n_phase = fbav_pkg::PH_AFIX;
				end
			end
			fbav_pkg::PH_AFIX, fbav_pkg::PH_TL, fbav_pkg::PH_DATA, fbav_pkg::PH_PAD: begin
				n_asum = n_asum + b;
				case (n_phase)
					fbav_pkg::PH_AFIX: begin
						if (n_pos == 4'd2 && b != 8'd0) begin
							n_errs = n_errs | fbav_pkg::E_LANG;
							if (!cae_q) begin
								n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
							end
						end
						if (!halt) begin
							n_pos = n_pos + 4'd1;
							if (n_pos >= 4'd6)
								n_phase = fbav_pkg::PH_TL;
						end
					end
					fbav_pkg::PH_TL: begin
						if (n_fcnt == 3'd4) begin
							// file ID: must leave room and be empty
							if (left0 < 12'd3 || b == fbav_pkg::END_MARK) begin
								n_errs = n_errs | fbav_pkg::E_PREDEF;
								if (!cae_q) begin
									n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
								end
							end
							if (!halt && b != fbav_pkg::END_MARK
									&& (b & fbav_pkg::TL_LEN_MASK) != 8'd0) begin
								n_errs = n_errs | fbav_pkg::E_FILEID;
								if (!cae_q) begin
									n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
								end
							end
							if (!halt)
								n_fcnt = 3'd5;
						end
						if (!halt) begin
							if (b == fbav_pkg::END_MARK) begin
								if (n_fcnt < 3'd4) begin
									n_errs = n_errs | fbav_pkg::E_PREDEF;
									if (!cae_q) begin
										n_phase = fbav_pkg::PH_IDLE; res = 1'b1; halt = 1'b1;
									end
								end
								if (!halt) begin
									n_phase = fbav_pkg::PH_PAD;
									if (left0 == 12'd1) begin
										n_errs = n_errs | fbav_pkg::E_CKMISS;
										if (!cae_q) begin
											n_phase = fbav_pkg::PH_IDLE; res = 1'b1;
										end
									end
								end
							end else begin
								if (n_fcnt < 3'd4)
									n_fcnt = n_fcnt + 3'd1;
								n_fbl = b[5:0];
								n_phase = (b[5:0] != 6'd0) ? fbav_pkg::PH_DATA : fbav_pkg::PH_TL;
							end
						end
					end
					fbav_pkg::PH_DATA: begin
						n_fbl = n_fbl - 6'd1;
						if (n_fbl == 6'd0)
							n_phase = fbav_pkg::PH_TL;
					end
					default: begin
						if (left0 > 12'd1 && b != 8'd0) begin
							n_errs = n_errs | fbav_pkg::E_PAD;
							if (!cae_q) begin
								n_phase = fbav_pkg::PH_IDLE; res = 1'b1;
							end
						end
					end
				endcase
				if (n_phase != fbav_pkg::PH_IDLE) begin
					n_left = n_left - 12'd1;
					if (n_left == 12'd0) begin
						halt = 1'b0;
						if (n_phase != fbav_pkg::PH_PAD) begin
							// area ended before the end marker
							if (n_fcnt <= 3'd4) begin
								n_errs = n_errs | fbav_pkg::E_PREDEF;
								if (!cae_q) halt = 1'b1;
							end
							if (!halt) begin
								n_errs = n_errs | fbav_pkg::E_END;
								if (!cae_q) halt = 1'b1;
							end
							if (!halt) begin
								n_errs = n_errs | fbav_pkg::E_CKMISS;
								if (!cae_q) halt = 1'b1;
							end
						end
						if (!halt && n_asum != 8'd0)
							n_errs = n_errs | fbav_pkg::E_CKBAD;
						n_phase = fbav_pkg::PH_IDLE;
						res = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fbav_pkg::PH_IDLE;
			pos_q <= 4'd0;
			left_q <= 12'd0;
			fbl_q <= 6'd0;
			fcnt_q <= 3'd0;
			hsum_q <= 8'd0;
			asum_q <= 8'd0;
			oldm_q <= 1'b1;
			errs_q <= '0;
			ver_q <= 8'd0;
			offs_q <= 8'd0;
		end else if (accept) begin
			phase_q <= n_phase;
			pos_q <= n_pos;
			left_q <= n_left;
			fbl_q <= n_fbl;
			fcnt_q <= n_fcnt;
			hsum_q <= n_hsum;
			asum_q <= n_asum;
			oldm_q <= n_oldm;
			errs_q <= n_errs;
			ver_q <= n_ver;
			offs_q <= n_offs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cae_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr == fbav_pkg::REG_CAE) begin
			cae_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res) begin
			out_data_q <= {3'd0, n_oldm, (n_errs == '0), n_errs};
		end
	end

`ifndef SYNTHESIS
	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11] == (m_tdata[10:0] == 11'd0)))
		else $error("image_valid disagrees with error flags");

	a_res_ends_parse: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res) |=> phase_q == fbav_pkg::PH_IDLE)
		else $error("result given while parse continues");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == fbav_pkg::PH_DATA |-> fbl_q != 6'd0)
		else $error("field data phase with no bytes left");

	a_area_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == fbav_pkg::PH_AFIX || phase_q == fbav_pkg::PH_TL
			|| phase_q == fbav_pkg::PH_DATA || phase_q == fbav_pkg::PH_PAD)
		|-> left_q != 12'd0)
		else $error("area walk with no bytes left");
`endif

endmodule

// ===== tb/sv/fru_board_area_validator_chk.sv =====
module fru_board_area_validator_chk #(
	parameter int AREA_UNIT = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fbav_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] image_byte
	input  logic                         s_tuser,   // [0] image_start
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [15:0]                  m_tdata,   // [10:0] error_flags, [11] image_valid, [12] old_layout
	output int                           fail_count,
	output int                           pending,
	output int                           results,
	output fbav_pkg::errs_t              flags_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		fbav_pkg::errs_t flags;
		logic            ok;
		logic            old;
	} verdict_t;

	verdict_t verdicts_due[$];

	// shadow of the parser
	logic             cae_q;
	fbav_pkg::phase_t ph;
	logic [11:0]      pos;
	logic [11:0]      area_left;
	logic [5:0]       fld_left;
	logic [2:0]       fld_cnt;
	logic [7:0]       hdr_sum;
	logic [7:0]       area_sum;
	logic             old_match;
	fbav_pkg::errs_t  errs;
	logic [15:0]      seen;
	bit               done;

	int              fails;
	int              nres;
	fbav_pkg::errs_t seen_or;
	verdict_t        got;
	verdict_t        want;

	function automatic void restart_state();
		pos = '0;
		area_left = '0;
		fld_left = '0;
		fld_cnt = '0;
		hdr_sum = '0;
		area_sum = '0;
		old_match = 1'b1;
		errs = '0;
		seen = '0;
	endfunction

	function automatic void close_parse();
		done = 1'b1;
		ph = fbav_pkg::PH_IDLE;
	endfunction

	// returns 1 when stop mode has ended the parse
	function automatic bit flag_fault(fbav_pkg::errs_t e);
		errs = errs | e;
		if (!cae_q) begin
			close_parse();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void close_with_sum();
		if (area_sum != 8'h00)
			errs = errs | fbav_pkg::E_CKBAD;
		close_parse();
	endfunction

	function automatic void area_ran_out();
		if (fld_cnt <= 3'd4 && flag_fault(fbav_pkg::E_PREDEF))
			return;
		if (flag_fault(fbav_pkg::E_END))
			return;
		if (flag_fault(fbav_pkg::E_CKMISS))
			return;
		close_with_sum();
	endfunction

	function automatic void open_field(logic [7:0] b);
		fld_left = b[5:0];
		ph = (fld_left != 6'd0) ? fbav_pkg::PH_DATA : fbav_pkg::PH_TL;
	endfunction

	function automatic void take_marker(logic [11:0] left);
		ph = fbav_pkg::PH_PAD;
		if (left == 12'd1)
			void'(flag_fault(fbav_pkg::E_CKMISS));
	endfunction

	function automatic void type_length_byte(logic [7:0] b, logic [11:0] left);
		if (fld_cnt < 3'd4) begin
			if (b == fbav_pkg::END_MARK) begin
				if (flag_fault(fbav_pkg::E_PREDEF))
					return;
				take_marker(left);
				return;
			end
			fld_cnt = fld_cnt + 3'd1;
			open_field(b);
			return;
		end
		// file ID slot
		if (fld_cnt == 3'd4) begin
			if ((left < 12'd3 || b == fbav_pkg::END_MARK) && flag_fault(fbav_pkg::E_PREDEF))
				return;
			if (b != fbav_pkg::END_MARK && (b & fbav_pkg::TL_LEN_MASK) != 8'h00
					&& flag_fault(fbav_pkg::E_FILEID))
				return;
			fld_cnt = 3'd5;
		end
		if (b == fbav_pkg::END_MARK)
			take_marker(left);
		else
			open_field(b);
	endfunction

	function automatic void header_end();
		pos = '0;
		ph = fbav_pkg::PH_AVER;
		if (old_match)
			return;
		if (seen[7:0] != fbav_pkg::FMT_VERSION && flag_fault(fbav_pkg::E_HVER))
			return;
		if (hdr_sum != 8'h00 && flag_fault(fbav_pkg::E_HSUM))
			return;
		if (seen[15:8] != fbav_pkg::BOARD_OFFSET) begin
			errs = errs | fbav_pkg::E_OFFS;
			close_parse();
		end
	endfunction

	function automatic void area_length_byte(logic [7:0] b);
		logic [11:0] tot;
		logic        bad_ver;
		tot = old_match ? 12'(b) : 12'(b * AREA_UNIT);
		bad_ver = seen[7:0] != fbav_pkg::FMT_VERSION;
		pos = 12'd2;
		if (tot < 12'd6) begin
			if (flag_fault(fbav_pkg::E_PREDEF))
				return;
			if (bad_ver)
				errs = errs | fbav_pkg::E_AVER;
			if (tot <= 12'd2) begin
				errs = errs | fbav_pkg::E_END | fbav_pkg::E_CKMISS;
				if (tot == 12'd2 && area_sum != 8'h00)
					errs = errs | fbav_pkg::E_CKBAD;
				close_parse();
				return;
			end
		end else if (bad_ver && flag_fault(fbav_pkg::E_AVER)) begin
			return;
		end
		area_left = tot - 12'd2;
		ph = fbav_pkg::PH_AFIX;
	endfunction

	function automatic void area_content_byte(logic [7:0] b);
		logic [11:0] left;
		left = area_left;
		area_sum = area_sum + b;
		case (ph)
		fbav_pkg::PH_AFIX: begin
			if (pos == 12'd2 && b != 8'h00 && flag_fault(fbav_pkg::E_LANG))
				return;
			pos = pos + 12'd1;
			if (pos >= 12'd6)
				ph = fbav_pkg::PH_TL;
		end
		fbav_pkg::PH_TL: type_length_byte(b, left);
		fbav_pkg::PH_DATA: begin
			fld_left = fld_left - 6'd1;
			if (fld_left == 6'd0)
				ph = fbav_pkg::PH_TL;
		end
		default: begin
			if (left > 12'd1 && b != 8'h00 && flag_fault(fbav_pkg::E_PAD))
				return;
		end
		endcase
		if (ph == fbav_pkg::PH_IDLE)
			return;
		area_left = area_left - 12'd1;
		if (area_left == 12'd0) begin
			if (ph == fbav_pkg::PH_PAD)
				close_with_sum();
			else
				area_ran_out();
		end
	endfunction

	// one image byte; returns 1 with the verdict when the parse ends on it
	function automatic bit parse_image_byte(input logic [7:0] b, input logic st,
			output verdict_t v);
		v = '0;
		done = 1'b0;
		if (st) begin
			restart_state();
			ph = fbav_pkg::PH_HDR;
		end
		case (ph)
		fbav_pkg::PH_IDLE: return 1'b0;
		fbav_pkg::PH_HDR: begin
			hdr_sum = hdr_sum + b;
			if (b != fbav_pkg::OLD_HDR[pos[2:0]])
				old_match = 1'b0;
			if (pos == 12'd0)
				seen[7:0] = b;
			if (pos == 12'd3)
				seen[15:8] = b;
			pos = pos + 12'd1;
			if (pos >= 12'd8)
				header_end();
		end
		fbav_pkg::PH_AVER: begin
			area_sum = b;
			seen = {8'h00, b};
			pos = 12'd1;
			ph = fbav_pkg::PH_ALEN;
		end
		fbav_pkg::PH_ALEN: begin
			area_sum = area_sum + b;
			area_length_byte(b);
		end
		default: area_content_byte(b);
		endcase
		if (!done)
			return 1'b0;
		v.flags = errs;
		v.ok = (errs == '0);
		v.old = old_match;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_state();
			ph = fbav_pkg::PH_IDLE;
			cae_q = 1'b0;
			verdicts_due.delete();
			fails = 0;
			nres = 0;
			seen_or = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.flags = m_tdata[10:0];
				got.ok = m_tdata[11];
				got.old = m_tdata[12];
				if (verdicts_due.size() == 0) begin
					$error("result with nothing due: m_tdata 0x%0h", m_tdata);
					fails++;
				end else begin
					want = verdicts_due.pop_front();
					nres++;
					seen_or = seen_or | got.flags;
					if (got.flags !== want.flags) begin
						$error("error_flags: expected 0x%0h, got 0x%0h", want.flags, got.flags);
						fails++;
					end
					if (got.ok !== want.ok) begin
						$error("image_valid: expected %0b, got %0b", want.ok, got.ok);
						fails++;
					end
					if (got.old !== want.old) begin
						$error("old_layout: expected %0b, got %0b", want.old, got.old);
						fails++;
					end
				end
			end
			// a byte taken on the same edge as a write still sees the old mode
			if (s_tvalid && s_tready && parse_image_byte(s_tdata, s_tuser, want))
				verdicts_due.push_back(want);
			if (psel && penable && pwrite && pready && paddr == fbav_pkg::REG_CAE)
				cae_q = pwdata[0];
		end
		fail_count <= fails;
		pending <= verdicts_due.size();
		results <= nres;
		flags_seen <= seen_or;
	end

endmodule

// ===== tb/sv/fru_board_area_validator_tb.sv =====
module fru_board_area_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AREA_UNIT = 8;

	typedef struct {
		bit         old;
		logic [7:0] hver;
		logic [7:0] hoff;
		bit         hsum_bad;
		logic [7:0] aver;
		logic [7:0] lang;
		int         npre;
		int         fid_len;
		int         ncust;
		bit         marker;
		bit         pad_bad;
		bit         ck_bad;
		bit         len_set;
		logic [7:0] len_val;
		bit         mark_last;
		bit         flip;
		int         cut;
	} image_plan_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [fbav_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [7:0]                   s_tdata = '0;   // [7:0] image_byte
	logic                         s_tuser = 1'b0; // [0] image_start
	logic                         m_tvalid;
	logic                         m_tready = 1'b1;
	logic [15:0]                  m_tdata;        // [10:0] error_flags, [11] image_valid, [12] old_layout

	int              fail_count;
	int              pending;
	int              results;
	fbav_pkg::errs_t flags_seen;

	int gap_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int images_sent = 0;

	logic [7:0] img[$];

	fru_board_area_validator #(
		.AREA_LENGTH_UNIT(AREA_UNIT)
	) DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	fru_board_area_validator_chk #(
		.AREA_UNIT(AREA_UNIT)
	) u_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending), .results(results),
		.flags_seen(flags_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= stall_pct);

	initial begin
		#5_000_000;
		$display("** fru_board_area_validator: FAILED **");
		$finish;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	function automatic void add_field(int flen);
		logic [7:0] tl;
		tl = {2'($urandom_range(0, 3)), 6'(flen)};
		if (tl == fbav_pkg::END_MARK)
			tl = 8'h41;
		img.push_back(tl);
		repeat (flen) img.push_back(rand_byte());
	endfunction

	function automatic image_plan_t clean_plan(bit old_fmt);
		image_plan_t p;
		p.old = old_fmt;
		p.hver = fbav_pkg::FMT_VERSION;
		p.hoff = fbav_pkg::BOARD_OFFSET;
		p.hsum_bad = 1'b0;
		p.aver = fbav_pkg::FMT_VERSION;
		p.lang = 8'h00;
		p.npre = 4;
		p.fid_len = 0;
		p.ncust = $urandom_range(0, 2);
		p.marker = 1'b1;
		p.pad_bad = 1'b0;
		p.ck_bad = 1'b0;
		p.len_set = 1'b0;
		p.len_val = 8'h00;
		p.mark_last = 1'b0;
		p.flip = 1'b0;
		p.cut = 0;
		return p;
	endfunction

	// mostly well-formed images, the rest with one or two faults
	function automatic image_plan_t random_plan();
		image_plan_t p;
		p = clean_plan($urandom_range(0, 99) < 20);
		if ($urandom_range(0, 99) < 60)
			return p;
		repeat ($urandom_range(1, 2)) begin
			case ($urandom_range(0, 13))
			0: p.hver = rand_byte();
			1: p.hoff = rand_byte();
			2: p.hsum_bad = 1'b1;
			3: p.aver = rand_byte();
			4: p.lang = rand_byte();
			5: p.npre = $urandom_range(0, 3);
			6: p.fid_len = $urandom_range(1, 8);
			7: p.marker = 1'b0;
			8: p.pad_bad = 1'b1;
			9: p.ck_bad = 1'b1;
			10: begin
				p.len_set = 1'b1;
				p.len_val = $urandom_range(0, 1) ? rand_byte() : 8'($urandom_range(0, 8));
			end
			11: p.mark_last = 1'b1;
			12: p.flip = 1'b1;
			default: p.cut = $urandom_range(1, 40);
			endcase
		end
		return p;
	endfunction

	function automatic void build_image(image_plan_t p);
		logic [7:0] sum;
		logic [7:0] tl;
		int         body;
		int         total;
		int         pad_from;
		int         i;
		img.delete();
		if (p.old) begin
			for (i = 0; i < 8; i++)
				img.push_back(fbav_pkg::OLD_HDR[i]);
		end else begin
			img.push_back(p.hver);
			img.push_back(rand_byte());
			img.push_back(rand_byte());
			img.push_back(p.hoff);
			img.push_back(rand_byte());
			img.push_back(rand_byte());
			img.push_back(rand_byte());
			sum = '0;
			for (i = 0; i < 7; i++)
				sum = sum + img[i];
			sum = -sum;
			if (p.hsum_bad)
				sum = sum + 8'($urandom_range(1, 255));
			img.push_back(sum);
		end
		// version, length (filled in below), language, date
		img.push_back(p.aver);
		img.push_back(8'h00);
		img.push_back(p.lang);
		img.push_back(rand_byte());
		img.push_back(rand_byte());
		img.push_back(rand_byte());
		for (i = 0; i < 4 && i < p.npre; i++)
			add_field($urandom_range(0, 5));
		if (p.npre < 4) begin
			img.push_back(fbav_pkg::END_MARK);
		end else begin
			tl = 8'hC0 | 8'(p.fid_len);
			img.push_back(tl);
			if (tl != fbav_pkg::END_MARK) begin
				repeat (p.fid_len) img.push_back(rand_byte());
				repeat (p.ncust) add_field($urandom_range(0, 6));
				if (p.marker)
					img.push_back(fbav_pkg::END_MARK);
			end
		end
		body = img.size() - 8;
		if (p.mark_last)
			total = body;
		else if (p.old)
			total = body + 1 + $urandom_range(0, 3);
		else
			total = ((body + 8) / 8 + $urandom_range(0, 1)) * 8;
		pad_from = img.size();
		while (img.size() - 8 < total - 1)
			img.push_back(8'h00);
		if (p.pad_bad && img.size() > pad_from)
			img[$urandom_range(pad_from, img.size() - 1)] = 8'($urandom_range(1, 255));
		img[9] = p.len_set ? p.len_val : (p.old ? 8'(total) : 8'(total / 8));
		sum = '0;
		for (i = 8; i < img.size(); i++)
			sum = sum + img[i];
		sum = -sum;
		if (p.ck_bad)
			sum = sum + 8'($urandom_range(1, 255));
		img.push_back(sum);
		if (p.flip)
			img[$urandom_range(1, img.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
	endfunction

	// valid stays high between back-to-back requests
	task automatic send_request(input logic [7:0] b, input logic st);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_image(input image_plan_t p);
		int n;
		int i;
		build_image(p);
		n = (p.cut > 0 && p.cut < img.size()) ? p.cut : img.size();
		for (i = 0; i < n; i++)
			send_request(img[i], i == 0);
		items_sent += n;
		images_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fbav_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_directed();
		image_plan_t p;
		int          i;
		for (i = 0; i < 25; i++) begin
			p = clean_plan(1'b0);
			p.ncust = 1;
			case (i)
			1: p.old = 1'b1;
			2: p.hver = 8'h02;
			3: p.hoff = 8'h02;
			4: p.hoff = 8'h00;
			5: p.hsum_bad = 1'b1;
			6: p.aver = 8'h00;
			7: p.lang = 8'hFF;
			8: begin
				p.len_set = 1'b1;
				p.len_val = 8'h00;
			end
			9: begin
				p.old = 1'b1;
				p.len_set = 1'b1;
				p.len_val = 8'd2;
			end
			10: begin
				p.old = 1'b1;
				p.len_set = 1'b1;
				p.len_val = 8'd4;
				p.lang = 8'h80;
			end
			11: begin
				p.old = 1'b1;
				p.len_set = 1'b1;
				p.len_val = 8'd1;
			end
			12: p.npre = 1;
			13: p.fid_len = 1;
			14: p.fid_len = 5;
			15: p.marker = 1'b0;
			16: p.pad_bad = 1'b1;
			17: p.ck_bad = 1'b1;
			18: begin
				p.old = 1'b1;
				p.mark_last = 1'b1;
			end
			19: begin
				p.len_set = 1'b1;
				p.len_val = 8'hFF;
			end
			20: begin
				p.old = 1'b1;
				p.len_set = 1'b1;
				p.len_val = 8'hFF;
			end
			21: p.cut = 19;
			22: begin
				p.old = 1'b1;
				p.npre = 0;
			end
			default: ;
			endcase
			send_image(p);
		end
		// stray bytes while idle are dropped
		repeat (3) send_request(rand_byte(), 1'b0);
		for (i = 0; i < 24; i++)
			send_request(8'hFF, i == 0);
		for (i = 0; i < 24; i++)
			send_request(8'h00, i == 0);
		items_sent += 51;
		send_image(clean_plan(1'b1));
	endtask

	initial begin
		int ph;
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed images in collect mode, so most faults run on to the area end (a wrong offset still ends after the header)
		write_reg(fbav_pkg::REG_CAE, 32'd1);
		run_directed();
		wait_idle();

		for (ph = 0; ph < 8; ph++) begin
			write_reg(fbav_pkg::REG_CAE, 32'(ph % 2));
			case (ph / 2)
			0: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct = 53;
				stall_pct = 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct = 53;
			end
			default: begin
				gap_pct = 9;
				stall_pct = 9;
			end
			endcase
			target = items_sent + 80;
			while (items_sent < target) begin
				if ($urandom_range(0, 99) < 10)
					repeat ($urandom_range(1, 4)) send_request(rand_byte(), 1'b0);
				send_image(random_plan());
			end
			// a complete image leaves the parser idle before the next write
			send_image(clean_plan($urandom_range(0, 1)));
			wait_idle();
		end

		$display("Run covered %0d image bytes in %0d images, both error modes, four flow mixes.",
			items_sent, images_sent);
		$display("%0d results compared; error bits raised at least once: %b", results, flags_seen);
		if (fail_count == 0)
			$display("** fru_board_area_validator: PASSED **");
		else
			$display("** fru_board_area_validator: FAILED **");
		$finish;
	end

endmodule
